// ===== rtl/cdi_pkg.sv =====
// ----------------------------------------------------------------------------
// cdi_pkg
// Shared constants and codes for the calibrated distance interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cdi_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int FRACTION_BITS = 8;

  localparam int IDX_W       = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_IDX_W = 5;
  localparam int RAW_W       = 12;
  localparam int BASE_W      = 8;
  localparam int DIST_W      = 17;
  localparam int CLASS_W     = 2;
  localparam int CNT_W       = $clog2(FRACTION_BITS + 1);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CLASS_W-1:0] RC_INTERP = 2'd0;
  localparam logic [CLASS_W-1:0] RC_CLOSE  = 2'd1;
  localparam logic [CLASS_W-1:0] RC_FAR    = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET = 8'd3;

endpackage

`default_nettype wire

// ===== rtl/cdi_table.sv =====
// ----------------------------------------------------------------------------
// cdi_table
// Calibration table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdi_table import cdi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [RAW_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [RAW_W-1:0] rd_data
);

  logic [RAW_W-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/cdi_divider.sv =====
// ----------------------------------------------------------------------------
// cdi_divider
// Restoring divider producing the fraction num/den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdi_divider import cdi_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [RAW_W-1:0]         num,
  input  wire logic [RAW_W-1:0]         den,
  output logic                          done,
  output logic [FRACTION_BITS-1:0]      quotient
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [RAW_W-1:0]         rem_r, rem_nxt;
  logic [RAW_W-1:0]         den_r, den_nxt;
  logic [FRACTION_BITS-1:0] q_r, q_nxt;
  logic [RAW_W:0]           shifted;
  logic                     fits;

  // The numerator is always below the divisor, so the remainder stays in RAW_W bits.
  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = RAW_W'(shifted - {1'b0, den_r});
      end else begin
        rem_nxt = RAW_W'(shifted);
      end
      q_nxt   = FRACTION_BITS'({q_r, fits});
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ===== rtl/calibrated_distance_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// calibrated_distance_interpolator_unit
// Piecewise linear lookup of a distance from a proximity calibration table.
//
//   Channel  Direction  Handshake            Carries
//   in_      input      in_valid/in_stall    opcode, entry index, raw reading
//   out_     output     out_valid/out_stall  distance (Q8 mm), range class
//   cfg_     input      cfg_wr_en            base distance in mm
//
// A write transaction is taken while the unit is idle and gives no result.
// A lookup scans the table through the single read port, one entry a cycle,
// then runs the fraction through the bit-serial divider, one bit a cycle;
// a reading that matches no pair is classed close or far without division.
// Synchronous reset clears control, sets base to BASE_RESET; the table is kept.
// While a lookup runs, in_stall is high; a finished result waits in the
// output register for as long as out_stall is held.
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_distance_interpolator_unit import cdi_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_opcode,
  input  wire logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  wire logic [RAW_W-1:0]       in_raw_reading,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [DIST_W-1:0]           out_distance_q8,
  output logic [CLASS_W-1:0]          out_range_class,
  input  wire logic                   cfg_wr_en,
  input  wire logic [BASE_W-1:0]      cfg_wr_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [BASE_W-1:0]        base_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [RAW_W-1:0]         raw_r, raw_nxt;
  logic [RAW_W-1:0]         hi_r, hi_nxt;
  logic [RAW_W-1:0]         e0_r, e0_nxt;
  logic [DIST_W-1:0]        res_dist_r, res_dist_nxt;
  logic [CLASS_W-1:0]       res_class_r, res_class_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic [CLASS_W-1:0]       out_class_r, out_class_nxt;

  logic                     in_accept;
  logic                     tbl_wr_en;
  logic [IDX_W-1:0]         tbl_rd_addr;
  logic [RAW_W-1:0]         tbl_rd_data;
  logic                     div_start;
  logic                     div_done;
  logic [FRACTION_BITS-1:0] div_q;
  logic                     pair_hit;
  logic                     out_free;
  logic [DIST_W-1:0]        seg_dist;
  logic [DIST_W-1:0]        far_dist;

  assign in_stall  = state_r != ST_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign tbl_wr_en = in_accept && (in_opcode == OP_WRITE)
                     && (32'(in_entry_index) < 32'(TABLE_ENTRIES));

  // hi_r holds entry[idx_r]; the read data in the scan state is entry[idx_r+1].
  assign pair_hit = (raw_r <= hi_r) && (raw_r > tbl_rd_data);
  assign out_free = !out_valid_r || !out_stall;

  assign seg_dist = DIST_W'((32'(base_r) + 32'(idx_r)) << FRACTION_BITS);
  assign far_dist = DIST_W'((32'(base_r) + 32'(TABLE_ENTRIES)) << FRACTION_BITS);

  cdi_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (IDX_W'(in_entry_index)),
    .wr_data (in_raw_reading),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  cdi_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (hi_r - raw_r),
    .den      (hi_r - tbl_rd_data),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    raw_nxt       = raw_r;
    hi_nxt        = hi_r;
    e0_nxt        = e0_r;
    res_dist_nxt  = res_dist_r;
    res_class_nxt = res_class_r;
    tbl_rd_addr   = '0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_opcode == OP_LOOKUP)) begin
          raw_nxt   = in_raw_reading;
          idx_nxt   = '0;
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        hi_nxt      = tbl_rd_data;
        e0_nxt      = tbl_rd_data;
        tbl_rd_addr = IDX_W'(idx_r + 1'b1);
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        tbl_rd_addr = IDX_W'(idx_r + 2'd2);
        if (pair_hit) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (idx_r == IDX_W'(TABLE_ENTRIES - 2)) begin
          if (raw_r > e0_r) begin
            res_dist_nxt  = '0;
            res_class_nxt = RC_CLOSE;
          end else begin
            res_dist_nxt  = far_dist;
            res_class_nxt = RC_FAR;
          end
          state_nxt = ST_FIN;
        end else begin
          hi_nxt  = tbl_rd_data;
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_dist_nxt  = DIST_W'(seg_dist + DIST_W'(div_q));
          res_class_nxt = RC_INTERP;
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    out_class_nxt = out_class_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
      out_dist_nxt  = res_dist_r;
      out_class_nxt = res_class_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    raw_r       <= raw_nxt;
    hi_r        <= hi_nxt;
    e0_r        <= e0_nxt;
    res_dist_r  <= res_dist_nxt;
    res_class_r <= res_class_nxt;
    out_dist_r  <= out_dist_nxt;
    out_class_r <= out_class_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_distance_q8 = out_dist_r;
  assign out_range_class = out_class_r;

  // A new result only ever comes from the finishing state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result loaded outside the finishing state");

  // The divider only reports completion while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished while not awaited");

  // The scan never runs past the last entry pair.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> 32'(idx_r) <= 32'(TABLE_ENTRIES - 2))
    else $error("scan index beyond the last pair");

  // A finished division always yields an interpolated result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && div_done |=> res_class_r == RC_INTERP)
    else $error("interpolated result has the wrong class");

endmodule

`default_nettype wire

// ===== bench/calibrated_distance_interpolator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Calibrated distance interpolator testbench
// Loads calibration tables and looks up raw readings against them. Each
// lookup result is checked field by field against a scoreboard of predicted
// distances. Runs under several base distances with random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module calibrated_distance_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdi_pkg::*;

  localparam int LIMIT_CYCLES  = 400_000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int PRESSURE_HOLD = 400;
  localparam int PHASE_ITEMS   = 135;

  typedef struct packed {
    logic [DIST_W-1:0]  dist_q8;
    logic [CLASS_W-1:0] cls;
  } range_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_opcode = OP_WRITE;
  logic [ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic [RAW_W-1:0]       in_raw_reading = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DIST_W-1:0]      out_distance_q8;
  logic [CLASS_W-1:0]     out_range_class;
  logic                   cfg_wr_en = 1'b0;
  logic [BASE_W-1:0]      cfg_wr_data = '0;

  // Shadow copy of the block's state, updated as each transaction is accepted.
  logic [RAW_W-1:0]  cal_shadow [TABLE_ENTRIES];
  logic [BASE_W-1:0] base_shadow = BASE_RESET;
  logic [RAW_W-1:0]  table_plan [TABLE_ENTRIES];

  range_result_t expected_ranges [$];

  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int lookups_checked = 0;
  int writes_sent = 0;
  int base_settings = 0;

  calibrated_distance_interpolator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_entry_index  (in_entry_index),
    .in_raw_reading  (in_raw_reading),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_distance_q8 (out_distance_q8),
    .out_range_class (out_range_class),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic range_result_t interpolate_distance(input logic [RAW_W-1:0] raw);
    range_result_t res;
    logic [31:0]   span;
    logic [31:0]   num;
    logic [31:0]   frac;
    logic [31:0]   mm_q;
    bit            hit;
    res.dist_q8 = '0;
    res.cls     = RC_FAR;
    hit         = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      if (!hit && raw <= cal_shadow[i] && raw > cal_shadow[i+1]) begin
        span        = 32'(cal_shadow[i]) - 32'(cal_shadow[i+1]);
        num         = 32'(cal_shadow[i]) - 32'(raw);
        frac        = (num << FRACTION_BITS) / span;
        mm_q        = ((32'(base_shadow) + 32'(i)) << FRACTION_BITS) + frac;
        res.dist_q8 = mm_q[DIST_W-1:0];
        res.cls     = RC_INTERP;
        hit         = 1'b1;
      end
    end
    if (!hit) begin
      if (raw > cal_shadow[0]) begin
        res.dist_q8 = '0;
        res.cls     = RC_CLOSE;
      end else begin
        mm_q        = (32'(base_shadow) + 32'(TABLE_ENTRIES)) << FRACTION_BITS;
        res.dist_q8 = mm_q[DIST_W-1:0];
        res.cls     = RC_FAR;
      end
    end
    return res;
  endfunction

  // Most queries land inside the table's span; the rest sit on or just above
  // an entry, or anywhere in the 12-bit range.
  function automatic logic [RAW_W-1:0] pick_query();
    logic [RAW_W-1:0] raw;
    int               k;
    k = $urandom_range(TABLE_ENTRIES - 1);
    case ($urandom_range(9))
      0: raw = RAW_W'($urandom);
      1: raw = cal_shadow[k];
      2: raw = cal_shadow[k] + 1'b1;
      default: raw = RAW_W'($urandom_range(cal_shadow[0], cal_shadow[TABLE_ENTRIES-1]));
    endcase
    return raw;
  endfunction

  // Called at a clock edge; leaves the task at the edge of acceptance.
  task automatic send_item(input logic op, input logic [ENTRY_IDX_W-1:0] idx,
                           input logic [RAW_W-1:0] raw);
    if (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 14);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_raw_reading <= raw;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (op == OP_WRITE) begin
      if (idx < TABLE_ENTRIES) cal_shadow[idx] = raw;
      writes_sent++;
    end else begin
      expected_ranges.push_back(interpolate_distance(raw));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk);
    // A write gives no result, so the block may still be busy after the drain.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    base_shadow = value;
    base_settings++;
  endtask

  task automatic load_table();
    logic [ENTRY_IDX_W-1:0] scramble;
    logic [ENTRY_IDX_W-1:0] idx;
    scramble = ENTRY_IDX_W'($urandom);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      idx = ENTRY_IDX_W'(i) ^ scramble;
      send_item(OP_WRITE, idx, table_plan[idx]);
    end
  endtask

  task automatic plan_monotone();
    int level;
    int step;
    level = ($urandom_range(3) == 0) ? 4095 : $urandom_range(4095, 1024);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      table_plan[i] = RAW_W'(level);
      case ($urandom_range(9))
        0: step = 0;
        1: step = 1;
        default: step = $urandom_range(140, 1);
      endcase
      level = (level > step) ? level - step : 0;
    end
  endtask

  task automatic plan_noise();
    foreach (table_plan[i]) table_plan[i] = RAW_W'($urandom);
  endtask

  // Evenly falling table with a one-count pair at 10/11, a flat pair at
  // 20/21 and a last entry of zero.
  task automatic test_directed_table();
    logic [RAW_W-1:0] probes [11] = '{12'd4095, 12'd4001, 12'd4000, 12'd3999, 12'd2720,
                                      12'd2719, 12'd1441, 12'd1440, 12'd1, 12'd0,
                                      12'd2048};
    for (int i = 0; i < TABLE_ENTRIES; i++) table_plan[i] = RAW_W'(4000 - 128 * i);
    table_plan[11] = table_plan[10] - 1'b1;
    table_plan[21] = table_plan[20];
    table_plan[TABLE_ENTRIES-1] = '0;
    load_table();
    foreach (probes[i]) send_item(OP_LOOKUP, ENTRY_IDX_W'($urandom), probes[i]);
  endtask

  task automatic test_base_extremes();
    logic [RAW_W-1:0] probes [4] = '{12'd4000, 12'd1, 12'd0, 12'd4095};
    write_base('0);
    foreach (probes[i]) send_item(OP_LOOKUP, '0, probes[i]);
    write_base('1);
    foreach (probes[i]) send_item(OP_LOOKUP, '1, probes[i]);
  endtask

  task automatic test_backpressure();
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (24) send_item(OP_LOOKUP, ENTRY_IDX_W'($urandom), pick_query());
    steady = 1'b0;
  endtask

  task automatic test_random_phase(input logic [BASE_W-1:0] base, input bit noisy,
                                   input bit quiet);
    write_base(base);
    steady = quiet;
    if (noisy) plan_noise();
    else plan_monotone();
    load_table();
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(99) < 12)
        send_item(OP_WRITE, ENTRY_IDX_W'($urandom), RAW_W'($urandom));
      else
        send_item(OP_LOOKUP, ENTRY_IDX_W'($urandom), pick_query());
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = PRESSURE_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    range_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_ranges.size() == 0) begin
        $display("%0t: unexpected result: expected none, got distance %0d class %0d",
                 $time, out_distance_q8, out_range_class);
        mismatches++;
      end else begin
        want = expected_ranges.pop_front();
        lookups_checked++;
        if (out_distance_q8 !== want.dist_q8) begin
          $display("%0t: distance mismatch: expected %0d, got %0d",
                   $time, want.dist_q8, out_distance_q8);
          mismatches++;
        end
        if (out_range_class !== want.cls) begin
          $display("%0t: range class mismatch: expected %0d, got %0d",
                   $time, want.cls, out_range_class);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_table();
    test_base_extremes();
    test_backpressure();
    test_random_phase(8'($urandom), 1'b0, 1'b0);
    test_random_phase(8'd0, 1'b0, 1'b1);
    test_random_phase(8'd255, 1'b0, 1'b0);
    test_random_phase(8'($urandom), 1'b1, 1'b0);
    test_random_phase(BASE_RESET, 1'b0, 1'b0);
    test_random_phase(8'd128, 1'b1, 1'b0);

    wait_drained();
    if (expected_ranges.size() != 0) begin
      $display("%0d expected results never arrived", expected_ranges.size());
    end
    $display("Covered %0d table writes and %0d checked lookups over %0d base settings,",
             writes_sent, lookups_checked, base_settings);
    $display("including close, far, flat-pair and receiver hold-off cases; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_ranges.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
